// ----- design/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Widths, status and request codes, register map and defaults.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int unsigned MAX_PAGES_DEF  = 4096;
  localparam int unsigned PAGE_BYTES_DEF = 4096;

  localparam int unsigned LIM_W   = 13;  // page limit, used count, internal page index
  localparam int unsigned IDX_W   = 12;  // reported page index
  localparam int unsigned POFF_W  = 24;  // reported byte offset
  localparam int unsigned OFF_W   = 32;  // release offset
  localparam int unsigned WORD_W  = 64;  // bitmap word
  localparam int unsigned BIT_W   = 6;   // bit position inside a word
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [LIM_W-1:0] PAGE_LIMIT_RST = 13'd4096;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // register index is paddr[2]
  localparam logic REG_PAGE_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_FREE  = 2'd3
  } status_e;

endpackage

// ----- design/bpa_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/bitmap_page_allocator_core.sv -----
// ----------------------------------------------------------------------------
// Bitmap page allocator core
// First-fit page allocator over a bitmap of used bits held in a RAM, one
// 64-bit word per access, with a count of used pages and a page limit register.
//
//   channel   | signals                                  | handshake
//   ----------+------------------------------------------+---------------------
//   request   | op_i, release_offset_i                   | start & !busy
//   result    | status_o, page_num_o, page_offset_o,     | done_o, one cycle
//             | used_count_o                             |
//   config    | psel, penable, pwrite, paddr, pwdata     | APB, pready tied high
//
// Results show in the cycle after the deciding state. Acquire: answered from
// idle when the pool is full, else a fetch and a scan state per bitmap word
// from the lowest word that may hold a free bit, then the offset multiply.
// Release: likewise for a negative offset, else a pool size multiply and range
// compare, then the reciprocal divide by PAGE_BYTES, a bitmap fetch, the free
// test and, if freed, the offset multiply. After reset a clearing pass zeroes
// the bitmap RAM; busy stays high meanwhile. The receiver cannot stall.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_core
  import bpa_pkg::*;
#(
  parameter int unsigned MAX_PAGES  = MAX_PAGES_DEF,
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     op_i,
  input  logic signed [OFF_W-1:0]  release_offset_i,
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic [IDX_W-1:0]         page_num_o,
  output logic [POFF_W-1:0]        page_offset_o,
  output logic [LIM_W-1:0]         used_count_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready
);

  localparam int unsigned WORDS  = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int unsigned AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned CW     = AW + 1;
  localparam int unsigned BASE_W = CW + BIT_W;
  localparam int unsigned PBW    = $clog2(PAGE_BYTES + 1);
  localparam int unsigned MUL_W  = LIM_W + PBW;
  localparam int unsigned RCP_W  = MUL_W + 1;
  localparam int unsigned MP_W   = MUL_W + RCP_W;
  localparam int unsigned DIV_SH = MUL_W + $clog2(PAGE_BYTES);
  localparam longint unsigned RECIP =
    ((64'd1 << DIV_SH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
  localparam int unsigned REM_W  = OFF_W - 1;

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_FETCH  = 10'b0000000100,
    S_SCAN   = 10'b0000001000,
    S_RTOT   = 10'b0000010000,
    S_RCMP   = 10'b0000100000,
    S_DIV    = 10'b0001000000,
    S_RFETCH = 10'b0010000000,
    S_RTEST  = 10'b0100000000,
    S_OFS    = 10'b1000000000
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       cur_q, cur_d;
  logic [CW-1:0]       hint_q, hint_d;
  logic [LIM_W-1:0]    used_q, used_d;
  logic [LIM_W-1:0]    page_limit_q, page_limit_d;
  logic                done_q, done_d;
  status_e             status_q, status_d;
  logic [IDX_W-1:0]    pidx_q, pidx_d;
  logic [POFF_W-1:0]   poff_q, poff_d;
  logic [LIM_W-1:0]    idx_q, idx_d;
  logic [REM_W-1:0]    rem_q, rem_d;
  logic [MUL_W-1:0]    prod_q, prod_d;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [WORD_W-1:0]   rd_data;

  logic [LIM_W-1:0]    eff;
  logic [BASE_W-1:0]   base;
  logic                past_end;
  logic [31:0]         span;
  logic [WORD_W-1:0]   word_mask;
  logic [WORD_W-1:0]   free_bits;
  logic [WORD_W-1:0]   low_bit;
  logic [BIT_W-1:0]    bit_pos;
  logic [WORD_W-1:0]   set_word;
  logic [WORD_W-1:0]   clr_word;
  logic [CW-1:0]       rel_word;
  logic [MUL_W-1:0]    mul_a;
  logic [RCP_W-1:0]    mul_b;
  logic [MP_W-1:0]     mul_p;
  logic                cfg_wr;

  assign eff = (32'(page_limit_q) < 32'(MAX_PAGES)) ? page_limit_q : LIM_W'(MAX_PAGES);

  // scan datapath: usable free bits of the current word below the limit
  assign base      = {cur_q, BIT_W'(0)};
  assign past_end  = 32'(base) >= 32'(eff);
  assign span      = 32'(eff) - 32'(base);
  assign word_mask = (span >= 32'(WORD_W)) ? '1
                   : ((WORD_W'(1) << span[BIT_W-1:0]) - WORD_W'(1));
  assign free_bits = ~rd_data & word_mask;
  assign low_bit   = free_bits & (~free_bits + WORD_W'(1));
  assign set_word  = rd_data | low_bit;

  always_comb begin
    bit_pos = '0;
    for (int b = 0; b < WORD_W; b++) begin
      if (low_bit[b]) begin
        bit_pos = bit_pos | BIT_W'(b);
      end
    end
  end

  assign clr_word = rd_data & ~(WORD_W'(1) << idx_q[BIT_W-1:0]);
  assign rel_word = CW'(idx_q >> BIT_W);

  // shared multiplier: pool size, reciprocal divide by PAGE_BYTES, page offset
  assign mul_a = (state_q == S_DIV) ? rem_q[MUL_W-1:0] : MUL_W'(idx_q);
  assign mul_b = (state_q == S_DIV) ? RCP_W'(RECIP) : RCP_W'(PAGE_BYTES);
  assign mul_p = MP_W'(mul_a) * MP_W'(mul_b);

  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    hint_d       = hint_q;
    used_d       = used_q;
    page_limit_d = page_limit_q;
    done_d       = 1'b0;
    status_d     = status_q;
    pidx_d       = pidx_q;
    poff_d       = poff_q;
    idx_d        = idx_q;
    rem_d        = rem_q;
    prod_d       = prod_q;
    ram_we       = 1'b0;
    ram_waddr    = cur_q[AW-1:0];
    ram_wdata    = '0;
    ram_raddr    = (state_q == S_FETCH) ? cur_q[AW-1:0] : AW'(idx_q >> BIT_W);

    if (cfg_wr && (paddr[2] == REG_PAGE_LIMIT)) begin
      page_limit_d = pwdata[LIM_W-1:0];
    end

    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (cur_q == CW'(WORDS - 1)) begin
          cur_d   = '0;
          hint_d  = '0;
          state_d = S_IDLE;
        end else begin
          cur_d = cur_q + CW'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          if (op_i == OP_ACQUIRE) begin
            if (used_q >= eff) begin
              done_d   = 1'b1;
              status_d = ST_FULL;
              pidx_d   = '0;
              poff_d   = '0;
            end else begin
              cur_d   = hint_q;
              state_d = S_FETCH;
            end
          end else if (release_offset_i[OFF_W-1]) begin
            done_d   = 1'b1;
            status_d = ST_RANGE;
            pidx_d   = '0;
            poff_d   = '0;
          end else begin
            rem_d   = release_offset_i[REM_W-1:0];
            idx_d   = eff;
            state_d = S_RTOT;
          end
        end
      end

      S_FETCH: begin
        if (past_end) begin
          done_d   = 1'b1;
          status_d = ST_FULL;
          pidx_d   = '0;
          poff_d   = '0;
          state_d  = S_IDLE;
        end else begin
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        if (free_bits != '0) begin
          ram_we    = 1'b1;
          ram_wdata = set_word;
          idx_d     = LIM_W'({cur_q, bit_pos});
          used_d    = used_q + LIM_W'(1);
          if ((&set_word) && (cur_q == hint_q)) begin
            hint_d = hint_q + CW'(1);
          end
          state_d = S_OFS;
        end else begin
          // skip the hint past words that are completely used
          if ((&rd_data) && (cur_q == hint_q)) begin
            hint_d = hint_q + CW'(1);
          end
          cur_d   = cur_q + CW'(1);
          state_d = S_FETCH;
        end
      end

      S_RTOT: begin
        prod_d  = mul_p[MUL_W-1:0];
        state_d = S_RCMP;
      end

      S_RCMP: begin
        if (32'(rem_q) >= 32'(prod_q)) begin
          done_d   = 1'b1;
          status_d = ST_RANGE;
          pidx_d   = '0;
          poff_d   = '0;
          state_d  = S_IDLE;
        end else begin
          // offset below limit * PAGE_BYTES: fits MUL_W bits, quotient fits LIM_W
          state_d = S_DIV;
        end
      end

      S_DIV: begin
        idx_d   = LIM_W'(mul_p >> DIV_SH);
        state_d = S_RFETCH;
      end

      S_RFETCH: begin
        state_d = S_RTEST;
      end

      S_RTEST: begin
        if (!rd_data[idx_q[BIT_W-1:0]]) begin
          done_d   = 1'b1;
          status_d = ST_FREE;
          pidx_d   = '0;
          poff_d   = '0;
          state_d  = S_IDLE;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = AW'(idx_q >> BIT_W);
          ram_wdata = clr_word;
          if (used_q != '0) begin
            used_d = used_q - LIM_W'(1);
          end
          if (rel_word < hint_q) begin
            hint_d = rel_word;
          end
          state_d = S_OFS;
        end
      end

      S_OFS: begin
        done_d   = 1'b1;
        status_d = ST_OK;
        pidx_d   = idx_q[IDX_W-1:0];
        poff_d   = POFF_W'(mul_p);
        state_d  = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      cur_q        <= '0;
      hint_q       <= '0;
      used_q       <= '0;
      page_limit_q <= PAGE_LIMIT_RST;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_q        <= cur_d;
      hint_q       <= hint_d;
      used_q       <= used_d;
      page_limit_q <= page_limit_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    pidx_q   <= pidx_d;
    poff_q   <= poff_d;
    idx_q    <= idx_d;
    rem_q    <= rem_d;
    prod_q   <= prod_d;
  end

  bpa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS),
    .AW    (AW)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign page_num_o    = pidx_q;
  assign page_offset_o = poff_q;
  assign used_count_o  = used_q;
  assign pready        = 1'b1;
  assign prdata        = (paddr[2] == REG_PAGE_LIMIT) ? PDATA_W'(page_limit_q) : '0;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted item neither worked on nor answered");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (page_num_o == '0 && page_offset_o == '0))
    else $error("error result carries a page");

  a_hint_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hint_q <= CW'(WORDS))
    else $error("scan hint beyond bitmap");
`endif

endmodule

// ----- bench/bitmap_page_allocator_core_tb.sv -----
// ----------------------------------------------------------------------------
// Bitmap page allocator core testbench
// Drives acquire and release requests through the start/busy port and checks
// every result against a bit-level predictor of the bitmap, the used count
// and the page limit. The page limit is changed over APB between phases and
// read back. A directed part covers full pool, range and double-free cases;
// a random part follows, with random idle request cycles save at limit 8191.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_core_tb
  import bpa_pkg::*;
;

  localparam int CYCLE_LIMIT = 400_000;

  typedef struct packed {
    logic                    op;
    logic signed [OFF_W-1:0] offset;
  } page_req_t;

  typedef struct packed {
    status_e           status;
    logic [IDX_W-1:0]  page_num;
    logic [POFF_W-1:0] page_offset;
    logic [LIM_W-1:0]  used_count;
  } page_outcome_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    op_i = OP_ACQUIRE;
  logic signed [OFF_W-1:0] release_offset_i = '0;
  logic                    done_o;
  logic [1:0]              status_o;
  logic [IDX_W-1:0]        page_num_o;
  logic [POFF_W-1:0]       page_offset_o;
  logic [LIM_W-1:0]        used_count_o;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [PADDR_W-1:0]      paddr = '0;
  logic [PDATA_W-1:0]      pwdata = '0;
  logic [PDATA_W-1:0]      prdata;
  logic                    pready;

  // predictor state
  bit                page_used_map [MAX_PAGES_DEF];
  int unsigned       pages_in_use = 0;
  logic [LIM_W-1:0]  limit_reg = PAGE_LIMIT_RST;

  page_req_t     request_q [$];
  page_outcome_t outcome_q [$];
  int unsigned   queued_cnt = 0;
  int unsigned   accepted_cnt = 0;
  int unsigned   error_cnt = 0;
  int            cycle_cnt = 0;
  int unsigned   idle_pct = 23;
  int unsigned   plan_used = 0;
  logic          item_taken = 1'b0;

  bitmap_page_allocator_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .op_i             (op_i),
    .release_offset_i (release_offset_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .page_num_o       (page_num_o),
    .page_offset_o    (page_offset_o),
    .used_count_o     (used_count_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic flag_error(input string what);
    $display("ERROR at %0t: %s", $time, what);
    error_cnt++;
  endtask

  // First-fit allocate or free; updates the bitmap and count.
  function automatic page_outcome_t alloc_or_free(input logic op,
                                                  input logic signed [OFF_W-1:0] off);
    page_outcome_t     res;
    int unsigned       lim;
    int unsigned       idx;
    longint unsigned   pool_bytes;
    bit                found;
    lim = (limit_reg > MAX_PAGES_DEF) ? MAX_PAGES_DEF : limit_reg;
    res.status = ST_OK;
    idx = 0;
    found = 1'b0;
    if (op == OP_ACQUIRE) begin
      if (pages_in_use >= lim) begin
        res.status = ST_FULL;
      end else begin
        for (int unsigned i = 0; i < lim && !found; i++) begin
          if (!page_used_map[i]) begin
            idx = i;
            found = 1'b1;
          end
        end
        if (found) begin
          page_used_map[idx] = 1'b1;
          pages_in_use++;
        end else begin
          res.status = ST_FULL;
        end
      end
    end else begin
      pool_bytes = longint'(lim) * PAGE_BYTES_DEF;
      if (off < 0 || longint'(off) >= pool_bytes) begin
        res.status = ST_RANGE;
      end else begin
        idx = unsigned'(off) / PAGE_BYTES_DEF;
        if (idx >= lim) begin
          res.status = ST_RANGE;
        end else if (!page_used_map[idx]) begin
          res.status = ST_FREE;
        end else begin
          page_used_map[idx] = 1'b0;
          if (pages_in_use > 0) pages_in_use--;
        end
      end
    end
    if (res.status != ST_OK) idx = 0;
    res.page_num    = idx[IDX_W-1:0];
    res.page_offset = POFF_W'(longint'(idx) * PAGE_BYTES_DEF);
    res.used_count  = pages_in_use[LIM_W-1:0];
    return res;
  endfunction

  // Driver: present the next item at a falling edge, hold it until taken.
  always @(negedge clk_i) begin
    page_req_t req;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !item_taken) begin
      // hold
    end else if (request_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
      req = request_q.pop_front();
      start <= 1'b1;
      op_i <= req.op;
      release_offset_i <= req.offset;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: predict on acceptance, check results and register reads.
  always @(posedge clk_i) begin
    page_outcome_t want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("bitmap_page_allocator_core_tb NOT OK");
      $finish;
    end else begin
      item_taken <= rst_ni && start && !busy;
      if (rst_ni) begin
        if (done_o) begin
          if (outcome_q.size() == 0) begin
            flag_error("result with nothing outstanding");
          end else begin
            want = outcome_q.pop_front();
            if (status_o != want.status)
              flag_error($sformatf("status %0d, want %0d", status_o, want.status));
            if (page_num_o != want.page_num)
              flag_error($sformatf("page_num %0d, want %0d",
                                   page_num_o, want.page_num));
            if (page_offset_o != want.page_offset)
              flag_error($sformatf("page_offset %h, want %h",
                                   page_offset_o, want.page_offset));
            if (used_count_o != want.used_count)
              flag_error($sformatf("used_count %0d, want %0d",
                                   used_count_o, want.used_count));
          end
        end
        if (start && !busy) begin
          outcome_q.push_back(alloc_or_free(op_i, release_offset_i));
          accepted_cnt++;
        end
        if (psel && penable && pready) begin
          if (pwrite) begin
            if (paddr[2] == REG_PAGE_LIMIT) limit_reg = pwdata[LIM_W-1:0];
          end else if (paddr[2] == REG_PAGE_LIMIT && prdata != PDATA_W'(limit_reg)) begin
            flag_error($sformatf("page_limit read %0d, want %0d", prdata, limit_reg));
          end
        end
      end
    end
  end

  task automatic apb_cycle(input logic [PADDR_W-1:0] addr, input logic wr,
                           input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  // Set the limit with junk above the field, then read it back.
  task automatic set_page_limit(input int unsigned lim);
    apb_cycle({REG_PAGE_LIMIT, 2'b00}, 1'b1,
              {19'($urandom), LIM_W'(lim)});
    apb_cycle({REG_PAGE_LIMIT, 2'b00}, 1'b0, '0);
  endtask

  // Wait until every item is taken and answered, then let the block settle.
  task automatic wait_idle();
    while (accepted_cnt != queued_cnt || outcome_q.size() != 0 || busy)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic push_acquire();
    request_q.push_back('{op: OP_ACQUIRE, offset: OFF_W'($urandom)});
    queued_cnt++;
  endtask

  task automatic push_release(input logic [OFF_W-1:0] off);
    request_q.push_back('{op: OP_RELEASE, offset: off});
    queued_cnt++;
  endtask

  task automatic push_release_page(input int unsigned page);
    push_release(OFF_W'(page * PAGE_BYTES_DEF + $urandom_range(0, PAGE_BYTES_DEF - 1)));
  endtask

  initial begin : stimulus
    int unsigned phase_limit [7] = '{64, 65, 130, 8191, 17, 1, 4096};
    int unsigned phase_items [7] = '{80, 50, 100, 120, 40, 25, 35};
    int unsigned eff;
    int unsigned pick;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // default limit: fill a few pages, then bad and double releases
    repeat (6) push_acquire();
    push_release(OFF_W'(2 * PAGE_BYTES_DEF + 123));
    push_release(OFF_W'(2 * PAGE_BYTES_DEF));
    push_release(32'hFFFF_FFFF);
    push_release(32'h8000_0000);
    push_release(32'h7FFF_FFFF);
    push_release(OFF_W'(MAX_PAGES_DEF * PAGE_BYTES_DEF));
    push_release(OFF_W'(MAX_PAGES_DEF * PAGE_BYTES_DEF - 1));
    push_acquire();
    push_release(32'h0000_0000);
    push_acquire();
    wait_idle();

    // lower the limit below pages in use; the unmapped index must be ignored
    set_page_limit(3);
    apb_cycle({~REG_PAGE_LIMIT, 2'b00}, 1'b1, 32'h0000_0007);
    apb_cycle({REG_PAGE_LIMIT, 2'b00}, 1'b0, '0);
    push_acquire();
    push_release_page(4);
    push_release(OFF_W'(3 * PAGE_BYTES_DEF));
    push_release(OFF_W'(3 * PAGE_BYTES_DEF - 1));
    push_release_page(1);
    push_acquire();
    wait_idle();

    set_page_limit(0);
    push_acquire();
    push_release(32'h0000_0000);
    wait_idle();

    plan_used = 3;
    for (int p = 0; p < 7; p++) begin
      set_page_limit(phase_limit[p]);
      eff = (phase_limit[p] > MAX_PAGES_DEF) ? MAX_PAGES_DEF : phase_limit[p];
      idle_pct = (phase_limit[p] == 8191) ? 0 : 23;
      if (plan_used > eff) plan_used = eff;
      for (int n = 0; n < phase_items[p]; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          push_acquire();
          if (plan_used < eff) plan_used++;
        end else if (pick < 85) begin
          push_release_page($urandom_range(0, (plan_used + 1 > MAX_PAGES_DEF - 1) ?
                                              MAX_PAGES_DEF - 1 : plan_used + 1));
          if (plan_used > 0) plan_used--;
        end else if (pick < 90) begin
          push_release($urandom | 32'h8000_0000);
        end else if (pick < 95) begin
          push_release(OFF_W'(eff * PAGE_BYTES_DEF + $urandom_range(0, 32'h7F00_0000)));
        end else begin
          push_release(OFF_W'($urandom));
        end
        // hold off once mid-phase until every result is back
        if (phase_limit[p] == 130 && n == phase_items[p] / 2) wait_idle();
      end
      wait_idle();
    end

    repeat (30) @(negedge clk_i);
    if (error_cnt == 0) begin
      $display("bitmap_page_allocator_core_tb OK");
    end else begin
      $display("bitmap_page_allocator_core_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- bitmap_page_allocator_core.f -----
design/bpa_pkg.sv
design/bpa_ram.sv
design/bitmap_page_allocator_core.sv
bench/bitmap_page_allocator_core_tb.sv
